// File: hdl/lras_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lras_pkg
// shared types and constants of the line rasterizer
// ----------------------------------------------------------------------------
package lras_pkg;

   localparam int COLOUR_BITS = 8;

   // item opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // classification of one queued item
   typedef struct packed {
      logic is_load;
      logic major_is_b;
      logic minor_falls;
   } lras_ctrl_type;

   localparam int CTRL_BITS = $bits(lras_ctrl_type);

endpackage

// File: hdl/lras_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lras_req_if
// request channel: load or step items
// ----------------------------------------------------------------------------
interface lras_req_if #(
   parameter int COORD_BITS = 12
);
   logic                              valid;
   logic                              ready;
   logic                              op;
   logic [COORD_BITS-1:0]             start_a;
   logic [COORD_BITS-1:0]             start_b;
   logic [COORD_BITS-1:0]             end_a;
   logic [COORD_BITS-1:0]             end_b;
   logic [lras_pkg::COLOUR_BITS-1:0]  line_colour;

   modport source (
      output valid, op, start_a, start_b, end_a, end_b, line_colour,
      input  ready
   );
   modport sink (
      input  valid, op, start_a, start_b, end_a, end_b, line_colour,
      output ready
   );
endinterface

// File: hdl/lras_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lras_rsp_if
// response channel: one pixel per transfer
// ----------------------------------------------------------------------------
interface lras_rsp_if #(
   parameter int COORD_BITS = 12
);
   logic                              valid;
   logic                              ready;
   logic [COORD_BITS-1:0]             pixel_a;
   logic [COORD_BITS-1:0]             pixel_b;
   logic [lras_pkg::COLOUR_BITS-1:0]  pixel_value;
   logic                              last_pixel;

   modport source (
      output valid, pixel_a, pixel_b, pixel_value, last_pixel,
      input  ready
   );
   modport sink (
      input  valid, pixel_a, pixel_b, pixel_value, last_pixel,
      output ready
   );
endinterface

// File: hdl/lras_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lras_front
// classifies request items and sets up the major/minor geometry of a load
// ----------------------------------------------------------------------------
module lras_front #(
   parameter int COORD_BITS = 12
) (
   lras_req_if.sink                          req_chan,
   output logic                              push_valid,
   input  logic                              push_ready,
   output lras_pkg::lras_ctrl_type           push_ctrl,
   output logic [COORD_BITS-1:0]             push_lo_maj,
   output logic [COORD_BITS-1:0]             push_lo_min,
   output logic [COORD_BITS-1:0]             push_hi_maj,
   output logic [COORD_BITS-1:0]             push_dmaj,
   output logic signed [COORD_BITS:0]        push_dmin,
   output logic [lras_pkg::COLOUR_BITS-1:0]  push_colour
);

   localparam int N = COORD_BITS;

   logic signed [N:0]  da;
   logic signed [N:0]  db;
   logic signed [N:0]  da_neg;
   logic signed [N:0]  db_neg;
   logic [N-1:0]       abs_a;
   logic [N-1:0]       abs_b;
   logic               major_is_b;
   logic signed [N:0]  dmaj_raw;
   logic signed [N:0]  dmin_raw;
   logic signed [N:0]  dmin_neg;
   logic [N-1:0]       start_maj;
   logic [N-1:0]       end_maj;
   logic [N-1:0]       start_min;
   logic [N-1:0]       end_min;
   logic               swap;

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;

   assign da     = $signed({1'b0, req_chan.end_a}) - $signed({1'b0, req_chan.start_a});
   assign db     = $signed({1'b0, req_chan.end_b}) - $signed({1'b0, req_chan.start_b});
   assign da_neg = -da;
   assign db_neg = -db;
   assign abs_a  = da[N] ? da_neg[N-1:0] : da[N-1:0];
   assign abs_b  = db[N] ? db_neg[N-1:0] : db[N-1:0];

   // equal magnitudes make b the major axis
   assign major_is_b = !(abs_a > abs_b);

   always_comb begin
      if (major_is_b) begin
         dmaj_raw  = db;
         dmin_raw  = da;
         start_maj = req_chan.start_b;
         end_maj   = req_chan.end_b;
         start_min = req_chan.start_a;
         end_min   = req_chan.end_a;
      end else begin
         dmaj_raw  = da;
         dmin_raw  = db;
         start_maj = req_chan.start_a;
         end_maj   = req_chan.end_a;
         start_min = req_chan.start_b;
         end_min   = req_chan.end_b;
      end
   end

   assign swap     = dmaj_raw[N];
   assign dmin_neg = -dmin_raw;

   assign push_lo_maj = swap ? end_maj : start_maj;
   assign push_hi_maj = swap ? start_maj : end_maj;
   assign push_lo_min = swap ? end_min : start_min;
   assign push_dmaj   = major_is_b ? abs_b : abs_a;
   assign push_dmin   = swap ? dmin_neg : dmin_raw;
   assign push_colour = req_chan.line_colour;

   assign push_ctrl.is_load     = (req_chan.op == lras_pkg::OP_LOAD);
   assign push_ctrl.major_is_b  = major_is_b;
   assign push_ctrl.minor_falls = push_dmin[N];

endmodule

// File: hdl/lras_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lras_fifo
// short queue between the front and the back
// ----------------------------------------------------------------------------
module lras_fifo #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [WIDTH-1:0]  push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [WIDTH-1:0]  pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff;
   logic [PTR_BITS-1:0]  wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff;
   logic [PTR_BITS-1:0]  rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff;
   logic [CNT_BITS-1:0]  count_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/lras_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lras_back
// line state, midpoint stepping and the pixel output register
// ----------------------------------------------------------------------------
module lras_back #(
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  lras_pkg::lras_ctrl_type           pop_ctrl,
   input  logic [COORD_BITS-1:0]             pop_lo_maj,
   input  logic [COORD_BITS-1:0]             pop_lo_min,
   input  logic [COORD_BITS-1:0]             pop_hi_maj,
   input  logic [COORD_BITS-1:0]             pop_dmaj,
   input  logic signed [COORD_BITS:0]        pop_dmin,
   input  logic [lras_pkg::COLOUR_BITS-1:0]  pop_colour,
   lras_rsp_if.source                        rsp_chan
);

   localparam int N  = COORD_BITS;
   localparam int DW = N + 4;
   localparam int SW = N + 3;
   localparam int CW = lras_pkg::COLOUR_BITS;

   logic                  active_ff, active_in;
   logic                  major_is_b_ff, minor_falls_ff;
   logic [N-1:0]          pos_maj_ff, pos_maj_in;
   logic [N-1:0]          pos_min_ff, pos_min_in;
   logic [N-1:0]          major_end_ff;
   logic signed [DW-1:0]  decision_ff, decision_in;
   logic signed [SW-1:0]  step_straight_ff, step_diag_up_ff, step_diag_down_ff;
   logic [CW-1:0]         colour_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [N-1:0]          pixel_a_ff, pixel_b_ff;
   logic [CW-1:0]         pixel_value_ff;
   logic                  last_pixel_ff;

   logic                  out_free;
   logic                  do_load;
   logic                  do_emit;
   logic                  last;
   logic                  dec_le_zero;
   logic signed [DW-1:0]  dmin_d, dmaj_d;
   logic signed [SW-1:0]  dmin_s, dmaj_s;
   logic signed [DW-1:0]  load_decision;
   logic signed [SW-1:0]  load_straight, load_up, load_down;
   logic signed [SW-1:0]  step_sel;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign pop_ready = pop_ctrl.is_load || !active_ff || out_free;
   assign do_load   = pop_valid && pop_ctrl.is_load;
   assign do_emit   = pop_valid && !pop_ctrl.is_load && active_ff && out_free;

   assign last        = !(pos_maj_ff < major_end_ff);
   assign dec_le_zero = decision_ff[DW-1] || (decision_ff == '0);

   // load-time decision value and increments
   assign dmin_d = {{3{pop_dmin[N]}}, pop_dmin};
   assign dmaj_d = {4'b0000, pop_dmaj};
   assign dmin_s = {{2{pop_dmin[N]}}, pop_dmin};
   assign dmaj_s = {3'b000, pop_dmaj};
   assign load_decision = pop_ctrl.minor_falls ? (dmin_d <<< 1) + dmaj_d
                                               : (dmin_d <<< 1) - dmaj_d;
   assign load_straight = dmin_s <<< 1;
   assign load_up       = (dmin_s - dmaj_s) <<< 1;
   assign load_down     = (dmin_s + dmaj_s) <<< 1;

   always_comb begin
      if (!minor_falls_ff) begin
         step_sel = dec_le_zero ? step_straight_ff : step_diag_up_ff;
      end else begin
         step_sel = dec_le_zero ? step_diag_down_ff : step_straight_ff;
      end
   end

   always_comb begin
      active_in    = active_ff;
      pos_maj_in   = pos_maj_ff;
      pos_min_in   = pos_min_ff;
      decision_in  = decision_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (do_load) begin
         active_in   = 1'b1;
         pos_maj_in  = pop_lo_maj;
         pos_min_in  = pop_lo_min;
         decision_in = load_decision;
      end else if (do_emit) begin
         rsp_valid_in = 1'b1;
         if (last) begin
            active_in = 1'b0;
         end else begin
            pos_maj_in  = pos_maj_ff + 1'b1;
            decision_in = decision_ff + {step_sel[SW-1], step_sel};
            if (!minor_falls_ff && !dec_le_zero) begin
               pos_min_in = pos_min_ff + 1'b1;
            end else if (minor_falls_ff && dec_le_zero) begin
               pos_min_in = pos_min_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_maj_ff  <= pos_maj_in;
      pos_min_ff  <= pos_min_in;
      decision_ff <= decision_in;
      if (do_load) begin
         major_is_b_ff     <= pop_ctrl.major_is_b;
         minor_falls_ff    <= pop_ctrl.minor_falls;
         major_end_ff      <= pop_hi_maj;
         step_straight_ff  <= load_straight;
         step_diag_up_ff   <= load_up;
         step_diag_down_ff <= load_down;
         colour_ff         <= pop_colour;
      end
      if (do_emit) begin
         pixel_a_ff     <= major_is_b_ff ? pos_min_ff : pos_maj_ff;
         pixel_b_ff     <= major_is_b_ff ? pos_maj_ff : pos_min_ff;
         pixel_value_ff <= colour_ff;
         last_pixel_ff  <= last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_a     = pixel_a_ff;
   assign rsp_chan.pixel_b     = pixel_b_ff;
   assign rsp_chan.pixel_value = pixel_value_ff;
   assign rsp_chan.last_pixel  = last_pixel_ff;

endmodule

// File: hdl/line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer
// midpoint line engine: one pixel per step transfer
// ----------------------------------------------------------------------------
// req_chan carries load items (op 0: two endpoints and a gray value) and
// step items (op 1). A load produces no response; it drops any line in
// progress and sets up the new one. Each step while a line is active gives
// one pixel transfer on rsp_chan, with last_pixel set on the final endpoint;
// a step with no active line is consumed and gives nothing.
// Requests enter a two-entry queue after setup in the front logic; the back
// logic pops items and holds the pixel in an output register. A step passes
// through the queue entry and the output register before its pixel is
// valid. Sustained rate is one item per cycle while rsp_chan takes pixels,
// set by the combinational decision add and compare in the back logic.
// When rsp_chan stalls, step items wait in the queue and req_chan ready
// drops once it is full; loads behind a waiting pixel are still taken.
// Reset (synchronous) empties the queue, clears the output valid flag and
// leaves no line active.
// ----------------------------------------------------------------------------
module line_rasterizer #(
   parameter int COORD_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   lras_req_if.sink    req_chan,
   lras_rsp_if.source  rsp_chan
);

   localparam int N       = COORD_BITS;
   localparam int CW      = lras_pkg::COLOUR_BITS;
   localparam int ENTRY_W = lras_pkg::CTRL_BITS + 4 * N + (N + 1) + CW;

   logic                     push_valid, push_ready;
   lras_pkg::lras_ctrl_type  push_ctrl, pop_ctrl;
   logic [N-1:0]             push_lo_maj, push_lo_min, push_hi_maj, push_dmaj;
   logic signed [N:0]        push_dmin;
   logic [CW-1:0]            push_colour;
   logic [N-1:0]             pop_lo_maj, pop_lo_min, pop_hi_maj, pop_dmaj;
   logic signed [N:0]        pop_dmin;
   logic [CW-1:0]            pop_colour;
   logic                     pop_valid, pop_ready;
   logic [ENTRY_W-1:0]       push_data, pop_data;

   lras_front #(.COORD_BITS(N)) u_front (
      .req_chan    (req_chan),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_ctrl   (push_ctrl),
      .push_lo_maj (push_lo_maj),
      .push_lo_min (push_lo_min),
      .push_hi_maj (push_hi_maj),
      .push_dmaj   (push_dmaj),
      .push_dmin   (push_dmin),
      .push_colour (push_colour)
   );

   assign push_data = {push_ctrl, push_lo_maj, push_lo_min, push_hi_maj,
                       push_dmaj, push_dmin, push_colour};

   lras_fifo #(.WIDTH(ENTRY_W), .DEPTH(2)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_ctrl, pop_lo_maj, pop_lo_min, pop_hi_maj,
           pop_dmaj, pop_dmin, pop_colour} = pop_data;

   lras_back #(.COORD_BITS(N)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_ctrl   (pop_ctrl),
      .pop_lo_maj (pop_lo_maj),
      .pop_lo_min (pop_lo_min),
      .pop_hi_maj (pop_hi_maj),
      .pop_dmaj   (pop_dmaj),
      .pop_dmin   (pop_dmin),
      .pop_colour (pop_colour),
      .rsp_chan   (rsp_chan)
   );

endmodule
